// ===== sv/uep0_pkg.sv =====
// Shared types, codes and the fixed descriptor image for the endpoint 0 responder.
`default_nettype none
package uep0_pkg;

   typedef enum logic [1:0] {
      EV_SETUP    = 2'd0,
      EV_IN_READY = 2'd1,
      EV_BUS_RST  = 2'd2,
      EV_SOF      = 2'd3
   } ev_kind_type;

   typedef enum logic [1:0] {
      REQ_IDLE        = 2'd0,
      REQ_SET_ADDRESS = 2'd1,
      REQ_DESC_READ   = 2'd2,
      REQ_SET_CONFIG  = 2'd3
   } active_req_type;

   localparam logic [7:0] BREQ_SET_ADDRESS    = 8'd5;
   localparam logic [7:0] BREQ_DESC_READ      = 8'd6;
   localparam logic [7:0] BREQ_SET_CONFIG     = 8'd9;
   localparam logic [6:0] SETUP_PACKET_BYTES  = 7'd8;
   localparam logic [6:0] ADDR_MASK           = 7'h7f;

   localparam int ROM_BYTES   = 87;
   localparam int ROM_ENTRIES = 7;

   localparam logic [7:0] ROM_BYTE_TABLE [ROM_BYTES] = '{
      8'd18, 8'd1, 8'h10, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'd64, 8'h12, 8'h00, 8'h34, 8'h00,
      8'h78, 8'h56, 8'd5, 8'd1, 8'd2, 8'd1,
      8'd9, 8'd2, 8'd41, 8'd0, 8'd1, 8'd1, 8'd3, 8'h80, 8'd50,
      8'd9, 8'd4, 8'd0, 8'd0, 8'd0, 8'h02, 8'h02, 8'h00, 8'd4,
      8'd9, 8'd4, 8'd1, 8'd0, 8'd2, 8'h0A, 8'h00, 8'h00, 8'd4,
      8'd7, 8'd5, 8'h81, 8'd2, 8'd64, 8'd0, 8'd1,
      8'd7, 8'd5, 8'h02, 8'd2, 8'd64, 8'd0, 8'd1,
      8'd4, 8'd3, 8'h09, 8'h04,
      8'd6, 8'd3, 8'h6d, 8'd0, 8'h61, 8'd0,
      8'd6, 8'd3, 8'h70, 8'd0, 8'h72, 8'd0,
      8'd6, 8'd3, 8'h73, 8'd0, 8'h6e, 8'd0,
      8'd6, 8'd3, 8'h69, 8'd0, 8'h6e, 8'd0
   };

   localparam logic [15:0] ROM_KEY_TABLE [ROM_ENTRIES] = '{
      16'h0100, 16'h0200, 16'h0300, 16'h0301, 16'h0302, 16'h0303, 16'h0304
   };
   localparam logic [15:0] ROM_START_TABLE [ROM_ENTRIES] = '{
      16'd0, 16'd18, 16'd59, 16'd63, 16'd69, 16'd75, 16'd81
   };
   localparam logic [15:0] ROM_LEN_TABLE [ROM_ENTRIES] = '{
      16'd18, 16'd41, 16'd4, 16'd6, 16'd6, 16'd6, 16'd6
   };

   function automatic logic [7:0] rom_byte(input logic [15:0] idx);
      logic [7:0] b;
      b = 8'd0;
      if (idx < 16'(ROM_BYTES)) begin
         b = ROM_BYTE_TABLE[idx[6:0]];
      end
      return b;
   endfunction

   function automatic logic [15:0] rom_key(input logic [7:0] idx);
      logic [15:0] k;
      k = 16'd0;
      if (idx < 8'(ROM_ENTRIES)) begin
         k = ROM_KEY_TABLE[idx[2:0]];
      end
      return k;
   endfunction

   function automatic logic [15:0] rom_start(input logic [7:0] idx);
      logic [15:0] s;
      s = 16'd0;
      if (idx < 8'(ROM_ENTRIES)) begin
         s = ROM_START_TABLE[idx[2:0]];
      end
      return s;
   endfunction

   function automatic logic [15:0] rom_len(input logic [7:0] idx);
      logic [15:0] l;
      l = 16'd0;
      if (idx < 8'(ROM_ENTRIES)) begin
         l = ROM_LEN_TABLE[idx[2:0]];
      end
      return l;
   endfunction

endpackage
`default_nettype wire

// ===== sv/uep0_req_if.sv =====
// Event channel: valid/ready handshake with the endpoint 0 event fields.
`default_nettype none
interface uep0_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [6:0]  setup_bytes;
   logic [7:0]  request_code;
   logic [15:0] request_value;
   logic [15:0] request_length;

   modport source (
      output valid, req_type, setup_bytes, request_code, request_value, request_length,
      input  ready
   );
   modport sink (
      input  valid, req_type, setup_bytes, request_code, request_value, request_length,
      output ready
   );
endinterface
`default_nettype wire

// ===== sv/uep0_rsp_if.sv =====
// Result channel: valid/ready handshake with packet byte and status fields.
`default_nettype none
interface uep0_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        byte_valid;
   logic        packet_sent;
   logic        last;
   logic [6:0]  device_address;
   logic        address_enabled;
   logic        configured;
   logic        transfer_active;
   logic [15:0] reset_count;
   logic [15:0] frame_count;

   modport source (
      output valid, data_byte, byte_valid, packet_sent, last, device_address,
             address_enabled, configured, transfer_active, reset_count, frame_count,
      input  ready
   );
   modport sink (
      input  valid, data_byte, byte_valid, packet_sent, last, device_address,
             address_enabled, configured, transfer_active, reset_count, frame_count,
      output ready
   );
endinterface
`default_nettype wire

// ===== sv/uep0_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module uep0_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== sv/usb_ep0_standard_request_responder_top.sv =====
// Top level of the USB endpoint 0 standard request responder.
//
// channel   dir  handshake          beat
// req_chan  in   valid/ready        one bus event
// rsp_chan  out  valid/ready        one packet byte or one status word
// csr       in   APB, pready high   usb_enabled at address 0
//
// After reset all DESC_STORE_BYTES bytes of the descriptor RAM are loaded from the fixed image,
// with no event beat taken. A descriptor request searches the table entries in order, up to
// the smaller of DESC_ENTRIES and ROM_ENTRIES, then runs like an IN packet. An IN packet passes
// through planning, RAM read, output register and drain; a zero-length packet goes straight
// to the output register. A stall on rsp_chan holds the output register and the RAM read stage.
`default_nettype none
module usb_ep0_standard_request_responder_top
   import uep0_pkg::*;
#(
   parameter int DESC_STORE_BYTES = 128,
   parameter int DESC_ENTRIES     = 8,
   parameter int PACKET_BYTES     = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   uep0_req_if.sink         req_chan,
   uep0_rsp_if.source       rsp_chan,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output      logic [31:0] prdata,
   output      logic        pready
);
   localparam int AW = $clog2(DESC_STORE_BYTES);
   localparam int PW = $clog2(DESC_STORE_BYTES + 1);
   localparam int NW = $clog2(PACKET_BYTES + 1);
   localparam int EW = (DESC_ENTRIES > 1) ? $clog2(DESC_ENTRIES) : 1;
   localparam int ENTRY_COUNT = (ROM_ENTRIES < DESC_ENTRIES) ? ROM_ENTRIES : DESC_ENTRIES;

   typedef enum logic [4:0] {
      S_LOAD   = 5'b00001,
      S_IDLE   = 5'b00010,
      S_SEARCH = 5'b00100,
      S_PLAN   = 5'b01000,
      S_STREAM = 5'b10000
   } state_type;

   state_type      state_ff, state_in;
   logic           enabled_ff, enabled_in;
   logic [AW-1:0]  load_idx_ff, load_idx_in;
   active_req_type active_ff, active_in;
   logic [6:0]     addr_ff, addr_in;
   logic           addr_on_ff, addr_on_in;
   logic           config_ff, config_in;
   logic [15:0]    bus_cnt_ff, bus_cnt_in;
   logic [15:0]    sof_cnt_ff, sof_cnt_in;
   logic [PW-1:0]  pointer_ff, pointer_in;
   logic [PW-1:0]  end_ff, end_in;
   logic [NW-1:0]  issue_left_ff, issue_left_in;
   logic           rd_pend_ff, rd_pend_in;
   logic           out_valid_ff, out_valid_in;

   logic [7:0]     out_data_ff, out_data_in;
   logic           out_bv_ff, out_bv_in;
   logic           out_pkt_ff, out_pkt_in;
   logic           out_last_ff, out_last_in;
   logic           rd_last_ff, rd_last_in;
   logic [PW-1:0]  rd_addr_ff, rd_addr_in;
   logic [EW-1:0]  search_idx_ff, search_idx_in;
   logic [15:0]    key_ff, key_in;
   logic [15:0]    wlen_ff, wlen_in;

   logic           csr_write;
   logic           req_fire;
   logic           out_free;
   logic           move;
   logic           issue;
   logic [7:0]     ram_rdata;
   logic [15:0]    ent_start;
   logic [15:0]    ent_len;
   logic [15:0]    ent_len_raw;
   logic [15:0]    eff_len;
   logic [15:0]    end_sum;
   logic [PW-1:0]  plan_rem;
   logic [NW-1:0]  plan_n;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == 1'b0) ? {31'd0, enabled_ff} : 32'd0;

   assign req_chan.ready = (state_ff == S_IDLE) && !out_valid_ff;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign move     = (state_ff == S_STREAM) && rd_pend_ff && out_free;
   assign issue    = (state_ff == S_STREAM) && (issue_left_ff != '0) && (!rd_pend_ff || move);

   uep0_ram #(
      .WIDTH (8),
      .DEPTH (DESC_STORE_BYTES)
   ) u_desc_ram (
      .clock   (clock),
      .wr_en   (state_ff == S_LOAD),
      .wr_addr (load_idx_ff),
      .wr_data (rom_byte(16'(load_idx_ff))),
      .rd_en   (issue),
      .rd_addr (rd_addr_ff[AW-1:0]),
      .rd_data (ram_rdata)
   );

   always_comb begin
      ent_start = rom_start(8'(search_idx_ff));
      if (ent_start > 16'(DESC_STORE_BYTES)) begin
         ent_start = 16'(DESC_STORE_BYTES);
      end
      ent_len_raw = rom_len(8'(search_idx_ff));
      ent_len     = ent_len_raw;
      if (ent_start + ent_len_raw > 16'(DESC_STORE_BYTES)) begin
         ent_len = 16'(DESC_STORE_BYTES) - ent_start;
      end
      eff_len = (ent_len > wlen_ff) ? wlen_ff : ent_len;
      end_sum = ent_start + eff_len;
      plan_rem = end_ff - pointer_ff;
      plan_n   = (plan_rem > PW'(PACKET_BYTES)) ? NW'(PACKET_BYTES) : plan_rem[NW-1:0];
   end

   always_comb begin
      state_in      = state_ff;
      enabled_in    = enabled_ff;
      load_idx_in   = load_idx_ff;
      active_in     = active_ff;
      addr_in       = addr_ff;
      addr_on_in    = addr_on_ff;
      config_in     = config_ff;
      bus_cnt_in    = bus_cnt_ff;
      sof_cnt_in    = sof_cnt_ff;
      pointer_in    = pointer_ff;
      end_in        = end_ff;
      issue_left_in = issue_left_ff;
      rd_pend_in    = rd_pend_ff;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      out_bv_in     = out_bv_ff;
      out_pkt_in    = out_pkt_ff;
      out_last_in   = out_last_ff;
      rd_last_in    = rd_last_ff;
      rd_addr_in    = rd_addr_ff;
      search_idx_in = search_idx_ff;
      key_in        = key_ff;
      wlen_in       = wlen_ff;

      if (csr_write && (paddr[2] == 1'b0)) begin
         enabled_in = pwdata[0];
      end

      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_LOAD: begin
            load_idx_in = load_idx_ff + AW'(1);
            if (load_idx_ff == AW'(DESC_STORE_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire && enabled_ff) begin
               out_valid_in = 1'b1;
               out_data_in  = 8'd0;
               out_bv_in    = 1'b0;
               out_pkt_in   = 1'b0;
               out_last_in  = 1'b1;
               case (ev_kind_type'(req_chan.req_type))
                  EV_SETUP: begin
                     if (req_chan.setup_bytes == SETUP_PACKET_BYTES) begin
                        case (req_chan.request_code)
                           BREQ_SET_ADDRESS: begin
                              active_in  = REQ_SET_ADDRESS;
                              addr_in    = req_chan.request_value[6:0] & ADDR_MASK;
                              addr_on_in = 1'b0;
                           end
                           BREQ_DESC_READ: begin
                              active_in     = REQ_DESC_READ;
                              key_in        = req_chan.request_value;
                              wlen_in       = req_chan.request_length;
                              search_idx_in = '0;
                              out_valid_in  = 1'b0;
                              state_in      = S_SEARCH;
                           end
                           BREQ_SET_CONFIG: begin
                              active_in = REQ_SET_CONFIG;
                           end
                           default: begin
                              active_in = REQ_IDLE;
                           end
                        endcase
                     end
                  end
                  EV_IN_READY: begin
                     case (active_ff)
                        REQ_DESC_READ: begin
                           out_valid_in = 1'b0;
                           state_in     = S_PLAN;
                        end
                        REQ_SET_ADDRESS: begin
                           addr_on_in = 1'b1;
                           active_in  = REQ_IDLE;
                        end
                        REQ_SET_CONFIG: begin
                           config_in = 1'b1;
                           active_in = REQ_IDLE;
                        end
                        default: begin
                        end
                     endcase
                  end
                  EV_BUS_RST: begin
                     bus_cnt_in = bus_cnt_ff + 16'd1;
                  end
                  default: begin
                     sof_cnt_in = sof_cnt_ff + 16'd1;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (rom_key(8'(search_idx_ff)) == key_ff) begin
               pointer_in = ent_start[PW-1:0];
               end_in     = end_sum[PW-1:0];
               state_in   = S_PLAN;
            end else if (search_idx_ff == EW'(ENTRY_COUNT - 1)) begin
               pointer_in = '0;
               end_in     = '0;
               state_in   = S_PLAN;
            end else begin
               search_idx_in = search_idx_ff + EW'(1);
            end
         end
         S_PLAN: begin
            if (plan_n < NW'(PACKET_BYTES)) begin
               active_in = REQ_IDLE;
            end
            if (plan_n == '0) begin
               out_valid_in = 1'b1;
               out_data_in  = 8'd0;
               out_bv_in    = 1'b0;
               out_pkt_in   = 1'b1;
               out_last_in  = 1'b1;
               state_in     = S_IDLE;
            end else begin
               rd_addr_in    = pointer_ff;
               issue_left_in = plan_n;
               pointer_in    = pointer_ff + PW'(plan_n);
               state_in      = S_STREAM;
            end
         end
         S_STREAM: begin
            if (move) begin
               out_valid_in = 1'b1;
               out_data_in  = ram_rdata;
               out_bv_in    = 1'b1;
               out_pkt_in   = 1'b1;
               out_last_in  = rd_last_ff;
               rd_pend_in   = 1'b0;
            end
            if (issue) begin
               rd_pend_in    = 1'b1;
               rd_last_in    = (issue_left_ff == NW'(1));
               rd_addr_in    = rd_addr_ff + PW'(1);
               issue_left_in = issue_left_ff - NW'(1);
            end
            if ((issue_left_ff == '0) && !rd_pend_ff) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         enabled_ff    <= 1'b0;
         load_idx_ff   <= '0;
         active_ff     <= REQ_IDLE;
         addr_ff       <= '0;
         addr_on_ff    <= 1'b0;
         config_ff     <= 1'b0;
         bus_cnt_ff    <= '0;
         sof_cnt_ff    <= '0;
         pointer_ff    <= '0;
         end_ff        <= '0;
         issue_left_ff <= '0;
         rd_pend_ff    <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         enabled_ff    <= enabled_in;
         load_idx_ff   <= load_idx_in;
         active_ff     <= active_in;
         addr_ff       <= addr_in;
         addr_on_ff    <= addr_on_in;
         config_ff     <= config_in;
         bus_cnt_ff    <= bus_cnt_in;
         sof_cnt_ff    <= sof_cnt_in;
         pointer_ff    <= pointer_in;
         end_ff        <= end_in;
         issue_left_ff <= issue_left_in;
         rd_pend_ff    <= rd_pend_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff   <= out_data_in;
      out_bv_ff     <= out_bv_in;
      out_pkt_ff    <= out_pkt_in;
      out_last_ff   <= out_last_in;
      rd_last_ff    <= rd_last_in;
      rd_addr_ff    <= rd_addr_in;
      search_idx_ff <= search_idx_in;
      key_ff        <= key_in;
      wlen_ff       <= wlen_in;
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.data_byte       = out_data_ff;
   assign rsp_chan.byte_valid      = out_bv_ff;
   assign rsp_chan.packet_sent     = out_pkt_ff;
   assign rsp_chan.last            = out_last_ff;
   assign rsp_chan.device_address  = addr_ff;
   assign rsp_chan.address_enabled = addr_on_ff;
   assign rsp_chan.configured      = config_ff;
   assign rsp_chan.transfer_active = (active_ff != REQ_IDLE);
   assign rsp_chan.reset_count     = bus_cnt_ff;
   assign rsp_chan.frame_count     = sof_cnt_ff;

   a_no_accept_while_beat_waits: assert property (
      @(posedge clock) disable iff (reset) rsp_chan.valid |-> !req_chan.ready
   ) else $error("event beat accepted while a result beat waits");

   a_no_result_during_load: assert property (
      @(posedge clock) disable iff (reset) (state_ff == S_LOAD) |-> !rsp_chan.valid
   ) else $error("result beat during descriptor load");

   a_issue_fills_read_stage: assert property (
      @(posedge clock) disable iff (reset) issue |=> rd_pend_ff
   ) else $error("RAM read issued without holding its data");

   a_stream_drains_to_idle: assert property (
      @(posedge clock) disable iff (reset)
         (state_ff == S_STREAM) && (issue_left_ff == '0) && !rd_pend_ff |=> (state_ff == S_IDLE)
   ) else $error("stream did not return to idle after last byte");

endmodule
`default_nettype wire
